>>> hw/rtl/obbfa_pkg.sv
// ----------------------------------------------------------------------------
// obbfa_pkg
// Shared constants for the box face-axis overlap unit: default widths of the
// stored coordinates and of the unit axes, and the result code for "no axis".
// ----------------------------------------------------------------------------
package obbfa_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;

   // width of one input row component (signed Q16.16)
   localparam int IN_WIDTH = 32;

   localparam logic [2:0] AXIS_NONE = 3'd6;
   localparam logic [2:0] AXIS_LAST = 3'd5;

endpackage

>>> hw/rtl/obb_face_axis_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_unit
// Two oriented boxes, four rows each, tested for overlap on their six face
// axes with one shared multiplier, a bit-serial square root and a restoring
// divider under a small sequencer.
// ----------------------------------------------------------------------------
// A word without evaluate stores one row. A word with evaluate stores its
// row and then walks the six face axes, own box first, stopping at the first
// separating one. Each axis runs a load, a normalizing shift, squares on the
// multiplier, a square root (one result bit per cycle), a divide for each
// unit axis component, dot products on the multiplier, a drain and a
// compare; an all-zero row goes straight from the load to the compare. The
// start forms the centre offset and the end posts the result. The square
// root and the divider take most of each axis. The block takes no word
// while an evaluation runs; a finished result waits in the output register
// while the next word is taken.
module obb_face_axis_overlap_test_unit #(
   parameter int COORD_WIDTH = obbfa_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = obbfa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_box_select,
   input  logic [1:0]                             req_row_select,
   input  logic signed [obbfa_pkg::IN_WIDTH-1:0]  req_row_x,
   input  logic signed [obbfa_pkg::IN_WIDTH-1:0]  req_row_y,
   input  logic signed [obbfa_pkg::IN_WIDTH-1:0]  req_row_z,
   input  logic                                   req_evaluate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_overlap,
   output logic [2:0]                             rsp_separating_axis
);

   localparam int CW  = COORD_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int MW  = (CW + 1 > 33) ? CW + 1 : 33;   // multiplier operand
   localparam int PW  = 2 * MW;
   localparam int DW  = PW + 2;                         // dot of three terms
   localparam int SW  = DW + 4;                         // reach / gap
   localparam int NW  = 32 + FB + 1;                    // divider width
   localparam int UW  = FB + 2;                         // signed unit comp
   localparam int SQRT_STEPS = 32;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_DLOAD0 = 12'b0000_0000_0010,
      ST_DLOAD1 = 12'b0000_0000_0100,
      ST_VLOAD  = 12'b0000_0000_1000,
      ST_SHIFT  = 12'b0000_0001_0000,
      ST_SQ     = 12'b0000_0010_0000,
      ST_SQW    = 12'b0000_0100_0000,
      ST_SQRT   = 12'b0000_1000_0000,
      ST_DIVI   = 12'b0001_0000_0000,
      ST_DIV    = 12'b0010_0000_0000,
      ST_DOT    = 12'b0100_0000_0000,
      ST_CMP    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic                 done_ff, done_in;      // result waiting to post
   logic signed [CW-1:0] rows_ff [8][3];
   logic signed [CW-1:0] rows_in [8][3];
   logic [2:0]           axis_ff, axis_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [1:0]           comp_ff, comp_in;
   logic [2:0]           grp_ff, grp_in;
   logic signed [CW-1:0] vec_ff [3];
   logic signed [CW-1:0] vec_in [3];
   logic [31:0]          mag_ff [3];
   logic [31:0]          mag_in [3];
   logic signed [CW:0]   d_ff [3];
   logic signed [CW:0]   d_in [3];
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 pv_ff, pv_in;
   logic                 psq_ff, psq_in;
   logic                 plast_ff, plast_in;
   logic                 pgap_ff, pgap_in;
   logic [63:0]          x_ff, x_in;
   logic [63:0]          r_ff, r_in;
   logic [63:0]          b_ff, b_in;
   logic [NW-1:0]        rem_ff, rem_in;
   logic [NW-1:0]        dsh_ff, dsh_in;
   logic [FB:0]          q_ff, q_in;
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] u_in [3];
   logic signed [DW-1:0] dot_ff, dot_in;
   logic [SW-1:0]        reach_ff, reach_in;
   logic [SW-1:0]        gap_ff, gap_in;
   logic [2:0]           res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_overlap_ff, rsp_overlap_in;
   logic [2:0]           rsp_axis_ff, rsp_axis_in;

   logic [2:0]           rd_addr;
   logic signed [MW-1:0] mul_a, mul_b;
   logic                 accept;

   function automatic logic signed [CW-1:0] sat_coord(
      input logic signed [obbfa_pkg::IN_WIDTH-1:0] raw
   );
      logic signed [63:0] ext;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      ext = 64'(raw);
      hi  = (64'sd1 <<< (CW - 1)) - 64'sd1;
      lo  = -hi - 64'sd1;
      if (ext > hi) begin
         ext = hi;
      end else if (ext < lo) begin
         ext = lo;
      end
      return ext[CW-1:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [CW-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (e < 0) begin
         e = -e;
      end
      return e[31:0];
   endfunction

   assign req_ready           = (state_ff == ST_IDLE) && !done_ff;
   assign accept              = req_valid && req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_overlap         = rsp_overlap_ff;
   assign rsp_separating_axis = rsp_axis_ff;

   // row read port: one row address per cycle
   always_comb begin
      unique case (state_ff)
         ST_DLOAD0: rd_addr = 3'd3;
         ST_DLOAD1: rd_addr = 3'd7;
         ST_DOT:    rd_addr = (grp_ff < 3'd3) ? grp_ff : grp_ff + 3'd1;
         default:   rd_addr = (axis_ff < 3'd3) ? axis_ff : axis_ff + 3'd1;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == ST_SQ) begin
         mul_a = MW'($signed({1'b0, mag_ff[cnt_ff[1:0]]}));
         mul_b = mul_a;
      end else if (grp_ff == 3'd6) begin
         mul_a = MW'(d_ff[comp_ff]);
         mul_b = MW'(u_ff[comp_ff]);
      end else begin
         mul_a = MW'(rows_ff[rd_addr][comp_ff]);
         mul_b = MW'(u_ff[comp_ff]);
      end
   end

   always_comb begin
      logic signed [DW-1:0] s;
      logic [DW-1:0]        s_abs;
      logic [63:0]          rb;
      logic [NW-1:0]        rem_t;
      logic [FB:0]          q_t;
      logic                 sep;
      logic                 any_big;

      state_in       = state_ff;
      done_in        = done_ff;
      rows_in        = rows_ff;
      axis_in        = axis_ff;
      cnt_in         = cnt_ff;
      comp_in        = comp_ff;
      grp_in         = grp_ff;
      vec_in         = vec_ff;
      mag_in         = mag_ff;
      d_in           = d_ff;
      prod_in        = mul_a * mul_b;
      pv_in          = 1'b0;
      psq_in         = 1'b0;
      plast_in       = 1'b0;
      pgap_in        = 1'b0;
      x_in           = x_ff;
      r_in           = r_ff;
      b_in           = b_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      q_in           = q_ff;
      u_in           = u_ff;
      dot_in         = dot_ff;
      reach_in       = reach_ff;
      gap_in         = gap_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_overlap_in = rsp_overlap_ff;
      rsp_axis_in    = rsp_axis_ff;
      s              = '0;
      s_abs          = '0;
      rb             = r_ff + b_ff;
      rem_t          = rem_ff;
      q_t            = q_ff;
      sep            = 1'b0;
      any_big        = 1'b0;

      // product consumer, working on the registered product in the cycle after the multiplier
      if (pv_ff) begin
         if (psq_ff) begin
            x_in = x_ff + prod_ff[63:0];
         end else begin
            s = dot_ff + DW'(prod_ff);
            if (plast_ff) begin
               s_abs = (s < 0) ? DW'(-s) : DW'(s);
               if (pgap_ff) begin
                  gap_in = {SW'(s_abs)} << 1;
               end else begin
                  reach_in = reach_ff + SW'(s_abs);
               end
               dot_in = '0;
            end else begin
               dot_in = s;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rows_in[{req_box_select, req_row_select}][0] = sat_coord(req_row_x);
               rows_in[{req_box_select, req_row_select}][1] = sat_coord(req_row_y);
               rows_in[{req_box_select, req_row_select}][2] = sat_coord(req_row_z);
               if (req_evaluate) begin
                  state_in = ST_DLOAD0;
               end
            end
         end
         ST_DLOAD0: begin
            for (int k = 0; k < 3; k++) begin
               vec_in[k] = rows_ff[rd_addr][k];
            end
            state_in = ST_DLOAD1;
         end
         ST_DLOAD1: begin
            for (int k = 0; k < 3; k++) begin
               d_in[k] = (CW+1)'(rows_ff[rd_addr][k]) - (CW+1)'(vec_ff[k]);
            end
            axis_in  = 3'd0;
            state_in = ST_VLOAD;
         end
         ST_VLOAD: begin
            for (int k = 0; k < 3; k++) begin
               vec_in[k] = rows_ff[rd_addr][k];
               mag_in[k] = mag32(rows_ff[rd_addr][k]);
            end
            x_in  = '0;
            r_in  = '0;
            b_in  = 64'd1 << 62;
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == 32'd0) begin
               // zero axis never separates
               state_in = ST_CMP;
               gap_in   = '0;
               reach_in = '0;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            any_big = ((mag_ff[0] | mag_ff[1] | mag_ff[2]) & 32'hC000_0000) != 32'd0;
            if (any_big) begin
               cnt_in   = '0;
               state_in = ST_SQ;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = mag_ff[k] << 1;
               end
            end
         end
         ST_SQ: begin
            pv_in  = 1'b1;
            psq_in = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               state_in = ST_SQW;
            end
         end
         ST_SQW: begin
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (x_ff >= rb) begin
               x_in = x_ff - rb;
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in   = b_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SQRT_STEPS - 1)) begin
               comp_in  = 2'd0;
               state_in = ST_DIVI;
            end
         end
         ST_DIVI: begin
            rem_in   = (NW'(mag_ff[comp_ff]) << FB) + NW'(r_ff[31:1]);
            dsh_in   = NW'(r_ff[31:0]) << FB;
            q_in     = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_t = rem_ff - dsh_ff;
               q_t   = {q_ff[FB-1:0], 1'b1};
            end else begin
               q_t   = {q_ff[FB-1:0], 1'b0};
            end
            rem_in = rem_t;
            q_in   = q_t;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(FB)) begin
               u_in[comp_ff] = vec_ff[comp_ff] < 0 ? -$signed({1'b0, q_t})
                                                   : $signed({1'b0, q_t});
               if (comp_ff == 2'd2) begin
                  grp_in   = '0;
                  comp_in  = '0;
                  dot_in   = '0;
                  reach_in = '0;
                  gap_in   = '0;
                  state_in = ST_DOT;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = ST_DIVI;
               end
            end
         end
         ST_DOT: begin
            pv_in    = 1'b1;
            plast_in = (comp_ff == 2'd2);
            pgap_in  = (grp_ff == 3'd6);
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               grp_in  = grp_ff + 3'd1;
               if (grp_ff == 3'd6) begin
                  state_in = ST_CMP;
                  cnt_in   = 6'd1;     // marks drain pending
               end
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_CMP: begin
            if (cnt_ff == 6'd1 && grp_ff == 3'd7) begin
               // last gap product lands this cycle
               cnt_in = '0;
               grp_in = '0;
            end else begin
               grp_in = '0;
               sep    = gap_ff > reach_ff;
               if (sep) begin
                  res_in   = axis_ff;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else if (axis_ff == obbfa_pkg::AXIS_LAST) begin
                  res_in   = obbfa_pkg::AXIS_NONE;
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + 3'd1;
                  state_in = ST_VLOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // post the result once the output register is free
      if (done_ff && (!rsp_valid_ff || rsp_ready)) begin
         done_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_overlap_in = (res_ff == obbfa_pkg::AXIS_NONE);
         rsp_axis_in    = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         cnt_ff       <= '0;
         grp_ff       <= '0;
         for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 3; k++) begin
               rows_ff[i][k] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= pv_in;
         cnt_ff       <= cnt_in;
         grp_ff       <= grp_in;
         rows_ff      <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff        <= axis_in;
      comp_ff        <= comp_in;
      vec_ff         <= vec_in;
      mag_ff         <= mag_in;
      d_ff           <= d_in;
      prod_ff        <= prod_in;
      psq_ff         <= psq_in;
      plast_ff       <= plast_in;
      pgap_ff        <= pgap_in;
      x_ff           <= x_in;
      r_ff           <= r_in;
      b_ff           <= b_in;
      rem_ff         <= rem_in;
      dsh_ff         <= dsh_in;
      q_ff           <= q_in;
      u_ff           <= u_in;
      dot_ff         <= dot_in;
      reach_ff       <= reach_in;
      gap_ff         <= gap_in;
      res_ff         <= res_in;
      rsp_overlap_ff <= rsp_overlap_in;
      rsp_axis_ff    <= rsp_axis_in;
   end

endmodule

>>> bench/obb_face_axis_overlap_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_unit_tb
// Loads box rows, fires evaluations and checks each overlap verdict and the
// first separating face axis against an in-bench model of the box test.
// ----------------------------------------------------------------------------
module obb_face_axis_overlap_test_unit_tb;

   localparam int FRAC = obbfa_pkg::FRAC_BITS_DEFAULT;
   localparam longint CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic        box;
      logic [1:0]  row;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        eval;
   } row_word_type;

   typedef struct packed {
      logic       overlap;
      logic [2:0] axis;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_box_select = 1'b0;
   logic [1:0] req_row_select = 2'd0;
   logic signed [obbfa_pkg::IN_WIDTH-1:0] req_row_x = '0;
   logic signed [obbfa_pkg::IN_WIDTH-1:0] req_row_y = '0;
   logic signed [obbfa_pkg::IN_WIDTH-1:0] req_row_z = '0;
   logic req_evaluate = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_overlap;
   logic [2:0] rsp_separating_axis;

   obb_face_axis_overlap_test_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_box_select(req_box_select), .req_row_select(req_row_select),
      .req_row_x(req_row_x), .req_row_y(req_row_y), .req_row_z(req_row_z),
      .req_evaluate(req_evaluate),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_overlap(rsp_overlap), .rsp_separating_axis(rsp_separating_axis)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   row_word_type pending_words[$];
   verdict_type  expected_verdicts[$];
   longint    box_coord[24];
   int        mismatches = 0;
   longint    cycles = 0;
   bit        stim_done = 1'b0;

   function automatic longint isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit axis of row at base; round to nearest after scaling up the row
   task automatic unit_axis(input int base, output longint u[3]);
      longint unsigned m[3], big, sum, n, q;
      for (int i = 0; i < 3; i++)
         m[i] = box_coord[base+i] < 0 ? -box_coord[base+i] : box_coord[base+i];
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      if (big == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return;
      end
      while (big < (64'd1 << 30)) begin
         big <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
      n = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) + (n >> 1)) / n;
         u[i] = box_coord[base+i] < 0 ? -longint'(q) : longint'(q);
      end
   endtask

   function automatic longint dot_at(int base, longint u[3]);
      return box_coord[base]*u[0] + box_coord[base+1]*u[1] + box_coord[base+2]*u[2];
   endfunction

   function automatic longint labs(longint v);
      return v < 0 ? -v : v;
   endfunction

   task automatic predict_word(input row_word_type w);
      int base, axis;
      longint d[3], u[3], reach, gap;
      base = w.box * 12 + w.row * 3;
      box_coord[base]   = longint'(signed'(w.x));
      box_coord[base+1] = longint'(signed'(w.y));
      box_coord[base+2] = longint'(signed'(w.z));
      if (!w.eval) return;
      axis = obbfa_pkg::AXIS_NONE;
      for (int k = 0; k < 3; k++) d[k] = box_coord[21+k] - box_coord[9+k];
      for (int a = 0; a < 6 && axis == obbfa_pkg::AXIS_NONE; a++) begin
         unit_axis((a / 3) * 12 + (a % 3) * 3, u);
         reach = 0;
         for (int k = 0; k < 3; k++)
            reach += labs(dot_at(k*3, u)) + labs(dot_at(12 + k*3, u));
         gap = 2 * labs(d[0]*u[0] + d[1]*u[1] + d[2]*u[2]);
         if (gap > reach) axis = a;
      end
      expected_verdicts.push_back({axis == obbfa_pkg::AXIS_NONE, 3'(axis)});
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic row_word_type make_word(bit box, bit [1:0] row, bit eval,
                                               int mode);
      row_word_type w;
      w.box = box; w.row = row; w.eval = eval;
      w.x = rand_coord(mode);
      w.y = rand_coord(mode == 3 ? 3 : (($urandom_range(0, 9) == 0) ? 4 : mode));
      w.z = rand_coord(mode == 3 ? 3 : (($urandom_range(0, 9) == 0) ? 4 : mode));
      return w;
   endfunction

   // stimulus
   initial begin
      row_word_type w;
      int mode;
      // directed: evaluate with empty boxes, extremes, zero rows, separated centres
      pending_words.push_back(make_word(0, 3, 1, 3));
      for (int b = 0; b < 2; b++)
         for (int r = 0; r < 4; r++)
            pending_words.push_back(make_word(b[0], r[1:0], r == 3, 2));
      pending_words.push_back(make_word(1, 3, 1, 0));
      pending_words.push_back(make_word(0, 3, 1, 1));
      pending_words.push_back(make_word(1, 1, 1, 3));
      pending_words.push_back(make_word(0, 0, 1, 4));
      w = make_word(1, 3, 1, 2);
      w.x = 32'h7fff_0000;
      pending_words.push_back(w);
      w = make_word(0, 3, 1, 2);
      w.x = 32'h8000_0000;
      pending_words.push_back(w);
      pending_words.push_back(make_word(1, 2, 1, 1));
      pending_words.push_back(make_word(0, 2, 0, 0));
      pending_words.push_back(make_word(0, 1, 1, 2));
      // random: mostly full box loads followed by an evaluation
      while (pending_words.size() < 1320) begin
         if ($urandom_range(0, 4) != 0) begin
            mode = ($urandom_range(0, 3) == 0) ? 4 : 2;
            for (int b = 0; b < 2; b++)
               for (int r = 0; r < 4; r++)
                  pending_words.push_back(make_word(b[0], r[1:0], 0,
                     ($urandom_range(0, 19) == 0) ? 3 : mode));
            pending_words.push_back(make_word(1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 1, mode));
         end else begin
            pending_words.push_back(make_word(1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               int'($urandom_range(0, 4))));
         end
      end
      stim_done = 1'b1;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         if (cycles >= 7) reset <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word({req_box_select, req_row_select, req_row_x, req_row_y,
                          req_row_z, req_evaluate});
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || pending_words.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               row_word_type w;
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_box_select <= w.box;
               req_row_select <= w.row;
               req_row_x <= w.x;
               req_row_y <= w.y;
               req_row_z <= w.z;
               req_evaluate <= w.eval;
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end
         end
      end
   end

   // monitor
   int stall = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected word: overlap %0d axis %0d",
                           rsp_overlap, rsp_separating_axis);
            end else begin
               verdict_type e;
               e = expected_verdicts.pop_front();
               if (e.overlap !== rsp_overlap || e.axis !== rsp_separating_axis) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("verdict: expected overlap %0d axis %0d, got %0d axis %0d",
                              e.overlap, e.axis, rsp_overlap, rsp_separating_axis);
               end
            end
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall <= stall - 1;
         end else if (rsp_ready && rsp_valid) begin
            rsp_ready <= 1'b0;
            stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatches == 0)
         $display("obb_face_axis_overlap_test_unit: match");
      else
         $display("obb_face_axis_overlap_test_unit: mismatch");
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("obb_face_axis_overlap_test_unit: mismatch");
      $finish;
   end

endmodule

>>> obb_face_axis_overlap_test_unit.f
hw/rtl/obbfa_pkg.sv
hw/rtl/obb_face_axis_overlap_test_unit.sv
bench/obb_face_axis_overlap_test_unit_tb.sv
